[rtl/eksc_pkg.sv]
// eksc_pkg: shared constants for the encoder knob speed command block
// register indexes, field widths, speed limit and the divide-by-100 reciprocal
// no dependencies
`default_nettype none

package eksc_pkg;

    // hold timer width and ceiling
    localparam int TIMER_BITS = 16;
    localparam logic [TIMER_BITS-1:0] TIMER_CEIL = {TIMER_BITS{1'b1}};

    // configuration fields
    localparam int DEBOUNCE_W = 16;
    localparam int NEUTRAL_W  = 11;
    localparam int SPAN_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // the timer and the debounce register are compared at the wider of the two
    localparam int CMP_W = (TIMER_BITS > DEBOUNCE_W) ? TIMER_BITS : DEBOUNCE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [NEUTRAL_W-1:0]  NEUTRAL_RST  = 11'd1500;
    localparam logic [SPAN_W-1:0]     SPAN_RST     = 9'd500;

    // result fields
    localparam int SPEED_W = 7;
    localparam int PULSE_W = 12;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    // span * speed fits 16 bits; x / 100 == (x * 83887) >> 23 for x below 2^16
    localparam int PROD_W   = SPAN_W + SPEED_W;
    localparam int RECIP_W  = 17;
    localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
    localparam int RECIP_SH = 23;
    localparam int QPROD_W  = PROD_W + RECIP_W;

endpackage

`default_nettype wire

[rtl/encoder_knob_speed_command.sv]
// encoder_knob_speed_command: quadrature knob speed count, debounced direction
// button and pulse width command, one sample per clock unless stalled
// depends on eksc_pkg
//
// Usage
// - input channel: one sample (enc_a, enc_b, button_level, tick) per transfer,
//   taken at an edge where i_valid is high and o_stall is low
// - output channel: one result per sample, in order; the receiver holds
//   i_stall high to keep the current result on the ports
// - configuration: i_cfg_valid with i_cfg_index / i_cfg_data, o_cfg_ready is
//   always high; write only while no sample is in flight; unknown index ignored
// - path: a sample accepted at an edge passes the input register, the state
//   update and multiply, the reciprocal multiply and the output register
//   before its result is on the ports
// - throughput: one sample per cycle unless stalled; the state update sits in one
//   pipeline stage so each sample sees the state left by the one before it
// - stall: the whole pipeline holds while a result waits and i_stall is high,
//   and o_stall follows so nothing is dropped
// - reset (i_rst_n low, synchronous): registers return to 50 / 1500 / 500,
//   count 0, pins and button assumed high (released), forward direction,
//   pipeline empty
`default_nettype none

module encoder_knob_speed_command (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // sample channel
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic                             i_enc_a,
    input  wire logic                             i_enc_b,
    input  wire logic                             i_button_level,
    input  wire logic                             i_tick,
    // result channel
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [eksc_pkg::PULSE_W-1:0]          o_pulse_width,
    output logic [eksc_pkg::SPEED_W-1:0]          o_speed_percent,
    output logic                                  o_reverse_on,
    output logic                                  o_press_event,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [eksc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [eksc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import eksc_pkg::*;

    // configuration
    logic [DEBOUNCE_W-1:0] r_debounce;
    logic [NEUTRAL_W-1:0]  r_neutral;
    logic [SPAN_W-1:0]     r_span;

    // block state
    logic [SPEED_W-1:0]    r_speed, n_speed;
    logic                  r_prev_a, r_prev_b;
    logic                  r_raw_prev;
    logic                  r_stable, n_stable;
    logic [TIMER_BITS-1:0] r_hold, n_hold;
    logic                  r_reverse, n_reverse;
    logic                  n_press;

    // pipeline
    logic                  en;
    logic                  r_in_valid;
    logic                  r_in_a, r_in_b, r_in_btn, r_in_tick;
    logic                  r_s1_valid;
    logic [PROD_W-1:0]     r_s1_prod;
    logic [SPEED_W-1:0]    r_s1_speed;
    logic                  r_s1_rev, r_s1_press;
    logic                  r_s2_valid;
    logic [SPAN_W-1:0]     r_s2_offset;
    logic [SPEED_W-1:0]    r_s2_speed;
    logic                  r_s2_rev, r_s2_press;
    logic                  r_out_valid;
    logic [PULSE_W-1:0]    r_out_pulse, n_pulse;
    logic [SPEED_W-1:0]    r_out_speed;
    logic                  r_out_rev, r_out_press;

    logic                  ch_a, ch_b, move, down;
    logic [SPEED_W-1:0]    stepped;
    logic [PROD_W-1:0]     n_prod;
    logic [QPROD_W-1:0]    qprod;

    assign en          = !(r_out_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_neutral  <= NEUTRAL_RST;
            r_span     <= SPAN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data[DEBOUNCE_W-1:0];
                CFG_NEUTRAL:  r_neutral  <= i_cfg_data[NEUTRAL_W-1:0];
                CFG_SPAN:     r_span     <= i_cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // encoder step, then button; an accepted press clears the count
    always_comb begin
        ch_a    = (r_in_a != r_prev_a);
        ch_b    = (r_in_b != r_prev_b);
        move    = ch_a ^ ch_b;
        down    = ch_a ? (r_in_a == r_in_b) : (r_in_a != r_in_b);
        stepped = r_speed;
        if (move) begin
            if (down) begin
                if (r_speed != '0) stepped = r_speed - SPEED_W'(1);
            end else begin
                if (r_speed < SPEED_MAX) stepped = r_speed + SPEED_W'(1);
            end
        end

        n_hold = r_hold;
        if (r_in_btn != r_raw_prev) begin
            n_hold = '0;
        end else if (r_in_tick && r_hold != TIMER_CEIL) begin
            n_hold = r_hold + TIMER_BITS'(1);
        end

        n_speed   = stepped;
        n_stable  = r_stable;
        n_reverse = r_reverse;
        n_press   = 1'b0;
        if (CMP_W'(n_hold) > CMP_W'(r_debounce) && r_in_btn != r_stable) begin
            n_stable = r_in_btn;
            if (!r_in_btn) begin
                n_reverse = !r_reverse;
                n_speed   = '0;
                n_press   = 1'b1;
            end
        end
        n_prod = PROD_W'(r_span) * PROD_W'(n_speed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= '0;
            r_prev_a   <= 1'b1;
            r_prev_b   <= 1'b1;
            r_raw_prev <= 1'b1;
            r_stable   <= 1'b1;
            r_hold     <= '0;
            r_reverse  <= 1'b0;
        end else if (en && r_in_valid) begin
            r_speed    <= n_speed;
            r_prev_a   <= r_in_a;
            r_prev_b   <= r_in_b;
            r_raw_prev <= r_in_btn;
            r_stable   <= n_stable;
            r_hold     <= n_hold;
            r_reverse  <= n_reverse;
        end
    end

    assign qprod = QPROD_W'(r_s1_prod) * QPROD_W'(RECIP_100);

    always_comb begin
        if (r_s2_rev) begin
            n_pulse = PULSE_W'(r_neutral) + PULSE_W'(r_s2_offset);
        end else if (NEUTRAL_W'(r_s2_offset) > r_neutral) begin
            n_pulse = '0;
        end else begin
            n_pulse = PULSE_W'(r_neutral - NEUTRAL_W'(r_s2_offset));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_in_valid  <= i_valid;
            r_s1_valid  <= r_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_a      <= i_enc_a;
            r_in_b      <= i_enc_b;
            r_in_btn    <= i_button_level;
            r_in_tick   <= i_tick;
            r_s1_prod   <= n_prod;
            r_s1_speed  <= n_speed;
            r_s1_rev    <= n_reverse;
            r_s1_press  <= n_press;
            r_s2_offset <= qprod[RECIP_SH+SPAN_W-1:RECIP_SH];
            r_s2_speed  <= r_s1_speed;
            r_s2_rev    <= r_s1_rev;
            r_s2_press  <= r_s1_press;
            r_out_pulse <= n_pulse;
            r_out_speed <= r_s2_speed;
            r_out_rev   <= r_s2_rev;
            r_out_press <= r_s2_press;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pulse_width   = r_out_pulse;
    assign o_speed_percent = r_out_speed;
    assign o_reverse_on    = r_out_rev;
    assign o_press_event   = r_out_press;

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed <= SPEED_MAX)
        else $error("speed count above limit");

    a_press_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_press) |-> (r_s1_speed == '0 && r_s1_prod == '0))
        else $error("press did not clear speed");

    a_press_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_in_valid && n_press) |=> (r_reverse != $past(r_reverse)))
        else $error("press did not toggle direction");

    a_pins_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_in_valid) |=> (r_prev_a == $past(r_in_a) && r_prev_b == $past(r_in_b)))
        else $error("encoder history not updated");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_speed) && $stable(r_hold) && $stable(r_s1_prod)))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

[sim/tb_encoder_knob_speed_command.sv]
// tb_encoder_knob_speed_command: self-checking bench for the knob speed command block
// directed table, then random quadrature and button traffic checked against a local predictor
// depends on eksc_pkg and encoder_knob_speed_command
`timescale 1ns / 1ps

module tb_encoder_knob_speed_command;
    import eksc_pkg::*;

    localparam int PIPE_LAT    = 3;
    localparam int N_DIR       = 28;
    localparam int N_SETS      = 9;
    localparam int RAND_SET    = 6;
    localparam int PHASE_ITEMS = 80;
    localparam int LONG_HOLD   = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // pin pairs {a, b} in count-up order
    localparam logic [1:0] GRAY_AB [4] = '{2'b11, 2'b01, 2'b00, 2'b10};

    typedef struct packed {
        logic [PULSE_W-1:0] pulse;
        logic [SPEED_W-1:0] speed;
        logic               rev;
        logic               press;
    } speed_cmd_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic                  a;
        logic                  b;
        logic                  btn;
        logic                  tick;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        speed_cmd_t            want;
    } dir_row_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] deb;
        logic [CFG_DATA_W-1:0] neu;
        logic [CFG_DATA_W-1:0] spn;
    } reg_set_t;

    // the last two sets go past the stated ranges: underflow clamp and widest sum
    localparam reg_set_t REG_SETS [N_SETS] = '{
        '{16'd0,     16'd1500,  16'd500},
        '{16'd3,     16'd1000,  16'd500},
        '{16'd1,     16'd2000,  16'd0},
        '{16'd65535, 16'd2000,  16'd500},
        '{16'd2,     16'd1234,  16'd333},
        '{16'd50,    16'd1500,  16'd500},
        '{16'd0,     16'd0,     16'd0},
        '{16'd0,     16'hF8C8,  16'd511},
        '{16'd1,     16'hFFFF,  16'hFFFF}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_enc_a;
    logic                  i_enc_b;
    logic                  i_button_level;
    logic                  i_tick;
    logic                  o_valid;
    logic                  i_stall;
    logic [PULSE_W-1:0]    o_pulse_width;
    logic [SPEED_W-1:0]    o_speed_percent;
    logic                  o_reverse_on;
    logic                  o_press_event;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    encoder_knob_speed_command dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_enc_a         (i_enc_a),
        .i_enc_b         (i_enc_b),
        .i_button_level  (i_button_level),
        .i_tick          (i_tick),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pulse_width   (o_pulse_width),
        .o_speed_percent (o_speed_percent),
        .o_reverse_on    (o_reverse_on),
        .o_press_event   (o_press_event),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // predictor state and registers
    logic [DEBOUNCE_W-1:0] k_debounce = DEBOUNCE_RST;
    logic [NEUTRAL_W-1:0]  k_neutral  = NEUTRAL_RST;
    logic [SPAN_W-1:0]     k_span     = SPAN_RST;
    logic [SPEED_W-1:0]    k_speed    = '0;
    logic                  k_prev_a   = 1'b1;
    logic                  k_prev_b   = 1'b1;
    logic                  k_btn_prev = 1'b1;
    logic                  k_btn_stable = 1'b1;
    logic [TIMER_BITS-1:0] k_hold     = '0;
    logic                  k_rev      = 1'b0;

    speed_cmd_t pending_cmds [$];
    dir_row_t   dir_rows [N_DIR];
    int         n_mismatch = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    logic       long_hold_req = 1'b0;

    function automatic speed_cmd_t knob_predict(input logic a, input logic b,
                                                input logic btn, input logic tick);
        speed_cmd_t  cmd;
        logic        chg_a;
        logic        chg_b;
        logic        move;
        logic        down;
        logic [31:0] off;
        logic [31:0] sum;
        chg_a = (a != k_prev_a);
        chg_b = (b != k_prev_b);
        move = 1'b0;
        down = 1'b0;
        cmd.press = 1'b0;
        if (chg_a && !chg_b) begin
            move = 1'b1;
            down = (a == b);
        end else if (chg_b && !chg_a) begin
            move = 1'b1;
            down = (a != b);
        end
        if (move) begin
            if (down && k_speed != 0)
                k_speed = k_speed - 1'b1;
            else if (!down && k_speed < SPEED_MAX)
                k_speed = k_speed + 1'b1;
        end
        k_prev_a = a;
        k_prev_b = b;
        // debounce runs after the encoder, so a press clears this sample's step
        if (btn != k_btn_prev)
            k_hold = '0;
        else if (tick && k_hold != TIMER_CEIL)
            k_hold = k_hold + 1'b1;
        if (k_hold > k_debounce && btn != k_btn_stable) begin
            k_btn_stable = btn;
            if (!btn) begin
                k_rev = ~k_rev;
                k_speed = '0;
                cmd.press = 1'b1;
            end
        end
        k_btn_prev = btn;
        off = k_span * k_speed / 100;
        sum = k_neutral + off;
        if (k_rev)
            cmd.pulse = sum[PULSE_W-1:0];
        else if (off > k_neutral)
            cmd.pulse = '0;
        else
            cmd.pulse = PULSE_W'(k_neutral - off);
        cmd.speed = k_speed;
        cmd.rev = k_rev;
        return cmd;
    endfunction

    function automatic dir_row_t row_smp(input logic a, input logic b,
                                         input logic btn, input logic tick);
        dir_row_t r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.a = a;
        r.b = b;
        r.btn = btn;
        r.tick = tick;
        return r;
    endfunction

    function automatic dir_row_t row_chk(input logic a, input logic b, input logic btn,
                                         input logic tick, input int pulse, input int speed,
                                         input logic rev, input logic press);
        dir_row_t r;
        r = row_smp(a, b, btn, tick);
        r.typed = 1'b1;
        r.want.pulse = pulse[PULSE_W-1:0];
        r.want.speed = speed[SPEED_W-1:0];
        r.want.rev = rev;
        r.want.press = press;
        return r;
    endfunction

    function automatic dir_row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        dir_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // offer one sample, wait for its transfer, then queue what it should produce
    task automatic send_sample(input logic a, input logic b, input logic btn, input logic tick,
                               input logic typed, input speed_cmd_t want);
        speed_cmd_t pred;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid        <= 1'b1;
        i_enc_a        <= a;
        i_enc_b        <= b;
        i_button_level <= btn;
        i_tick         <= tick;
        do @(posedge i_clk); while (o_stall);
        pred = knob_predict(a, b, btn, tick);
        pending_cmds.push_back(typed ? want : pred);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DEBOUNCE: k_debounce = data[DEBOUNCE_W-1:0];
            CFG_NEUTRAL:  k_neutral  = data[NEUTRAL_W-1:0];
            CFG_SPAN:     k_span     = data[SPAN_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver back-pressure, with an occasional long hold-off on request
    initial begin
        int hold_cnt;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // result checker
    initial begin
        speed_cmd_t got;
        speed_cmd_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.pulse = o_pulse_width;
                got.speed = o_speed_percent;
                got.rev   = o_reverse_on;
                got.press = o_press_event;
                if (pending_cmds.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: result with nothing pending: pulse %0d speed %0d",
                                 $realtime, got.pulse, got.speed);
                end else begin
                    want = pending_cmds.pop_front();
                    if (got !== want) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"%0t: mismatch, expected pulse %0d speed %0d rev %b ",
                                      "press %b, got pulse %0d speed %0d rev %b press %b"},
                                     $realtime, want.pulse, want.speed, want.rev, want.press,
                                     got.pulse, got.speed, got.rev, got.press);
                    end
                end
            end
        end
    end

    initial begin
        int                    ph;
        int                    i;
        int                    r;
        int                    run_left;
        int                    btn_left;
        int                    bounce_left;
        int                    btn_span;
        logic [1:0]            enc_pos;
        logic                  run_up;
        logic                  btn_level;
        logic                  btn;
        logic                  tick;
        logic [CFG_DATA_W-1:0] deb;
        logic [CFG_DATA_W-1:0] neu;
        logic [CFG_DATA_W-1:0] spn;
        dir_row_t              row;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_enc_a        <= 1'b1;
        i_enc_b        <= 1'b1;
        i_button_level <= 1'b1;
        i_tick         <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_DEBOUNCE;
        i_cfg_data     <= '0;

        dir_rows = '{
            row_chk(1, 1, 1, 0, 1500, 0, 0, 0),
            row_chk(0, 1, 1, 1, 1495, 1, 0, 0),
            row_chk(0, 0, 1, 0, 1490, 2, 0, 0),
            row_chk(1, 0, 1, 1, 1485, 3, 0, 0),
            row_chk(1, 1, 1, 0, 1480, 4, 0, 0),
            row_chk(0, 0, 1, 1, 1480, 4, 0, 0),   // both pins flip: no step
            row_chk(1, 0, 1, 0, 1475, 5, 0, 0),
            row_chk(0, 0, 1, 0, 1480, 4, 0, 0),
            row_chk(0, 1, 1, 1, 1485, 3, 0, 0),
            row_chk(1, 1, 1, 0, 1490, 2, 0, 0),
            row_chk(1, 0, 1, 0, 1495, 1, 0, 0),
            row_chk(0, 0, 1, 0, 1500, 0, 0, 0),
            row_chk(0, 1, 1, 0, 1500, 0, 0, 0),   // floor holds at zero
            row_chk(0, 1, 0, 1, 1500, 0, 0, 0),   // short press, not yet stable
            row_reg(CFG_DEBOUNCE, 16'd0),
            row_reg(CFG_NEUTRAL, 16'd2000),
            row_reg(CFG_SPAN, 16'd500),
            row_chk(0, 1, 0, 1, 2000, 0, 1, 1),
            row_smp(0, 0, 0, 1),
            row_smp(1, 0, 1, 1),
            row_smp(1, 1, 0, 1),
            row_smp(1, 1, 0, 1),
            row_smp(1, 1, 1, 1),
            row_smp(0, 1, 1, 1),
            row_smp(0, 0, 0, 1),
            row_chk(1, 0, 0, 1, 2000, 0, 0, 1),   // step and press together: count cleared
            row_reg(CFG_UNUSED, 16'hFFFF),
            row_smp(1, 1, 0, 0)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 38;
        rx_idle_pct = 54;
        for (i = 0; i < N_DIR; i++) begin
            row = dir_rows[i];
            if (row.kind == ROW_WRITE)
                write_reg(row.idx, row.data);
            else
                send_sample(row.a, row.b, row.btn, row.tick, row.typed, row.want);
        end

        enc_pos     = 2'd0;
        run_left    = 0;
        run_up      = 1'b1;
        btn_level   = 1'b0;
        btn_left    = 0;
        bounce_left = 0;
        for (ph = 0; ph < N_SETS; ph++) begin
            if (ph < 3) begin
                tx_idle_pct = 38;
                rx_idle_pct = 54;
            end else if (ph < 6) begin
                tx_idle_pct = 54;
                rx_idle_pct = 38;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            deb = REG_SETS[ph].deb;
            neu = REG_SETS[ph].neu;
            spn = REG_SETS[ph].spn;
            if (ph == RAND_SET) begin
                deb = CFG_DATA_W'($urandom_range(0, 8));
                neu = CFG_DATA_W'($urandom_range(1000, 2000));
                spn = CFG_DATA_W'($urandom_range(0, 500));
            end
            write_reg(CFG_DEBOUNCE, deb);
            write_reg(CFG_NEUTRAL, neu);
            write_reg(CFG_SPAN, spn);
            btn_span = (k_debounce < 60) ? 2 * k_debounce + 8 : 130;
            if (ph == 1 || ph == 4)
                long_hold_req = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // knob turned in runs, mostly clean quadrature with some jitter
                if (run_left == 0) begin
                    run_up   = ($urandom_range(99) < 70);
                    run_left = $urandom_range(1, 120);
                end
                run_left--;
                r = $urandom_range(99);
                if (r < 75)
                    enc_pos = run_up ? enc_pos + 2'd1 : enc_pos - 2'd1;
                else if (r >= 88 && r < 95)
                    enc_pos = enc_pos + 2'd2;
                else if (r >= 95)
                    enc_pos = run_up ? enc_pos - 2'd1 : enc_pos + 2'd1;
                // button held for runs, sometimes bouncing at the start
                if (btn_left == 0) begin
                    btn_level   = ~btn_level;
                    btn_left    = $urandom_range(1, btn_span);
                    bounce_left = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
                end
                btn_left--;
                if (bounce_left != 0) begin
                    bounce_left--;
                    btn = 1'($urandom_range(1));
                end else begin
                    btn = btn_level;
                end
                tick = ($urandom_range(3) != 0);
                send_sample(GRAY_AB[enc_pos][1], GRAY_AB[enc_pos][0], btn, tick, 1'b0, '0);
            end
        end

        wait_idle();
        if (n_mismatch == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
